// File: rtl/abm_pkg.sv
// Shared types and constants for the allocation bitmap block.
// Request kind codes and the per-byte evaluation result; no dependencies.
`timescale 1ns / 1ps

package abm_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [2:0] {
		KIND_TEST  = 3'd0,
		KIND_ALLOC = 3'd1,
		KIND_FIND  = 3'd2,
		KIND_COUNT = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	// evaluation of one bitmap byte
	typedef struct packed {
		logic       has_free;  // some bit clear after forcing
		logic [2:0] free_pos;  // lowest clear bit
		logic [3:0] ones;      // set bits in the raw byte
	} byte_eval_t;

	localparam int unsigned OUT_TDATA_W = 32;

endpackage

// File: rtl/allocation_bitmap_first_free.sv
// Allocation bitmap with first-free search; top level.
// Depends on abm_pkg, abm_ram and abm_byte_eval.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the kind (test,
//   allocate, find first free, count allocated, clear) and tdata the slot
//   index. Every request gives exactly one result item on m_axis.
//   Test and allocate read one byte, then select the bit or write the
//   byte back. Find first free reads bytes from the one that holds the
//   slot until a free bit turns up or the map ends; count allocated reads
//   every byte; clear map writes zero to every byte. Out of range test,
//   allocate and find requests and unused kinds go straight to the result.
//   Search and count walk the byte store one byte per cycle through its
//   single read port.
//   One request is in flight at a time. A new request is taken as soon as
//   the previous one has reached the output register, even while that
//   result is still waiting on m_axis_tready; a stalled receiver then holds
//   the next result inside until the output register frees up.
//   Reset: arst_n clears control state and starts a clearing pass that
//   writes zero to all (MAP_BITS+7)/8 bytes, one per cycle; s_axis_tready stays
//   low for those cycles.
`timescale 1ns / 1ps

module allocation_bitmap_first_free
	import abm_pkg::*;
#(
	parameter int unsigned MAP_BITS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [15:0]            s_axis_tdata,  // [15:0] slot_index
	input  logic [2:0]             s_axis_tuser,  // [2:0] kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] is_allocated, [1] found, [13:2] found_index,
	// [26:14] allocated_count, [31:27] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int unsigned MAP_BYTES = (MAP_BITS + 7) / 8;
	localparam int unsigned AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int unsigned CW        = $clog2(MAP_BITS + 1);
	localparam int unsigned TAIL_BITS = MAP_BITS % 8;
	localparam logic [7:0]  TAIL_MASK = (TAIL_BITS == 0) ? 8'hFF :
		8'((1 << TAIL_BITS) - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_BIT   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t        state_q;
	kind_t         kind_q;
	logic [15:0]   idx_q;
	logic [AW-1:0] cur_q;
	logic          first_q;
	logic          clr_resp_q;
	logic [CW-1:0] cnt_q;
	logic          res_alloc_q;
	logic          res_found_q;
	logic [11:0]   res_fidx_q;
	logic [12:0]   res_cnt_q;
	logic          out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic          accept;
	logic          in_range;
	logic          at_last;
	logic          out_free;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [7:0]    force_used;
	byte_eval_t    ev;
	logic [CW-1:0] cnt_next;
	logic [15:0]   fidx16;
	logic [16:0]   cnt17;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_range      = {1'b0, s_axis_tdata} < 17'(MAP_BITS);
	assign at_last       = (cur_q == LAST_ADDR);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = 8'd0;
		mem_re    = 1'b0;
		mem_raddr = cur_q + AW'(1);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_re    = accept;
				mem_raddr = (kind_t'(s_axis_tuser) == KIND_COUNT) ? '0 :
					s_axis_tdata[AW+2:3];
			end
			ST_BIT: begin
				mem_we    = (kind_q == KIND_ALLOC);
				mem_wdata = mem_rdata | (8'd1 << idx_q[2:0]);
			end
			ST_SCAN: begin
				mem_re = !at_last;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	abm_ram #(
		.DEPTH(MAP_BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// bits below the search start and past the map end count as used
	always_comb begin
		force_used = 8'd0;
		if (first_q && kind_q == KIND_FIND) begin
			force_used = force_used | ~(8'hFF << idx_q[2:0]);
		end
		if (at_last) begin
			force_used = force_used | ~TAIL_MASK;
		end
	end

	abm_byte_eval u_eval (
		.data      (mem_rdata),
		.force_used(force_used),
		.ev        (ev)
	);

	assign cnt_next = cnt_q + CW'(ev.ones);
	assign fidx16   = 16'({cur_q, ev.free_pos});
	assign cnt17    = 17'(cnt_next);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cur_q      <= '0;
			clr_resp_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cur_q <= cur_q + AW'(1);
					if (at_last) begin
						cur_q   <= '0;
						state_q <= clr_resp_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						clr_resp_q <= 1'b0;
						cur_q      <= s_axis_tdata[AW+2:3];
						state_q    <= ST_RESP;
						case (kind_t'(s_axis_tuser))
							KIND_TEST, KIND_ALLOC, KIND_FIND: begin
								if (in_range) begin
									state_q <= (kind_t'(s_axis_tuser) == KIND_FIND) ?
										ST_SCAN : ST_BIT;
								end
							end
							KIND_COUNT: begin
								cur_q   <= '0;
								state_q <= ST_SCAN;
							end
							KIND_CLEAR: begin
								cur_q      <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_BIT: begin
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					cur_q <= cur_q + AW'(1);
					if (at_last || (kind_q == KIND_FIND && ev.has_free)) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= kind_t'(s_axis_tuser);
			idx_q       <= s_axis_tdata;
			first_q     <= 1'b1;
			cnt_q       <= '0;
			res_alloc_q <= (kind_t'(s_axis_tuser) == KIND_TEST) && !in_range;
			res_found_q <= 1'b0;
			res_fidx_q  <= 12'd0;
			res_cnt_q   <= 13'd0;
		end
		if (state_q == ST_BIT && kind_q == KIND_TEST) begin
			res_alloc_q <= mem_rdata[idx_q[2:0]];
		end
		if (state_q == ST_SCAN) begin
			first_q <= 1'b0;
			cnt_q   <= cnt_next;
			if (kind_q == KIND_FIND && ev.has_free) begin
				res_found_q <= 1'b1;
				res_fidx_q  <= fidx16[11:0];
			end
			if (kind_q == KIND_COUNT && at_last) begin
				res_cnt_q <= cnt17[12:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			out_data_q <= OUT_TDATA_W'({res_cnt_q, res_fidx_q, res_found_q, res_alloc_q});
		end
	end

endmodule

// File: rtl/abm_ram.sv
// Byte-wide single-port-write, single-port-read bitmap store.
// Read data is registered. Uses no package items.
`timescale 1ns / 1ps

module abm_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/abm_byte_eval.sv
// Per-byte evaluation: lowest free bit after a forced-used mask, and popcount.
// Depends on abm_pkg for the result struct.
`timescale 1ns / 1ps

module abm_byte_eval
	import abm_pkg::*;
(
	input  logic [7:0]  data,
	input  logic [7:0]  force_used,
	output byte_eval_t  ev
);

	logic [7:0] busy;

	// priority search from bit 0 and bit count
	always_comb begin
		busy        = data | force_used;
		ev.has_free = 1'b0;
		ev.free_pos = 3'd0;
		ev.ones     = 4'd0;
		for (int b = 7; b >= 0; b--) begin
			if (!busy[b]) begin
				ev.has_free = 1'b1;
				ev.free_pos = 3'(b);
			end
		end
		for (int b = 0; b < 8; b++) begin
			ev.ones = ev.ones + 4'(data[b]);
		end
	end

endmodule

// File: rtl/abm_checker.sv
// Port-level checks for the allocation bitmap top level, bound to it below.
// Depends on abm_pkg for the output data width.
`timescale 1ns / 1ps

module abm_checker
	import abm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// one request in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while previous one still in work");

	// no found flag means index zero
	a_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[13:2] == 12'd0)
		else $error("found_index nonzero without found");

	// a result answers one kind only, padding stays zero
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
			m_axis_tdata[31:27] == 5'd0)
		else $error("result mixes fields of several kinds");

endmodule

bind allocation_bitmap_first_free abm_checker u_abm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

// File: tb/allocation_bitmap_first_free_tb.sv
// Testbench for the allocation bitmap block: a scoreboard class keeps its own
// copy of the slot map, predicts each result and checks every result item.
// Depends on abm_pkg and the allocation_bitmap_first_free RTL.
`timescale 1ns / 1ps

module allocation_bitmap_first_free_tb;
	import abm_pkg::*;

	localparam int unsigned MAP_BITS   = 4096;
	localparam int unsigned MAP_BYTES  = (MAP_BITS + 7) / 8;
	localparam int unsigned N_ITEMS    = 850;
	localparam int unsigned LIMIT      = 2000000;
	localparam int unsigned IDLE_PCT   = 11;
	localparam int unsigned HOLD_CYCLES = 300;

	// kind codes the block does not use; they must still give one zero result
	localparam logic [2:0] KIND_SPARE_5 = 3'd5;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	typedef struct {
		bit        is_allocated;
		bit        found;
		bit [11:0] found_index;
		bit [12:0] allocated_count;
	} slot_result_t;

	// shadow slot map and the queue of results still owed by the block
	class bitmap_scoreboard;
		bit [7:0]     map_bytes[MAP_BYTES];
		slot_result_t owed[$];
		int unsigned  failures;

		function bit slot_taken(int unsigned idx);
			if (idx >= MAP_BITS)
				return 1'b1;
			return map_bytes[idx >> 3][idx & 7];
		endfunction

		// apply one accepted request to the shadow map and queue its result
		function void note_request(logic [2:0] kind, logic [15:0] idx);
			slot_result_t r;
			r = '{default: 0};
			case (kind)
				KIND_TEST: r.is_allocated = slot_taken(idx);
				KIND_ALLOC: begin
					if (idx < MAP_BITS)
						map_bytes[idx >> 3][idx & 7] = 1'b1;
				end
				KIND_FIND: begin
					for (int unsigned i = idx; i < MAP_BITS; i++) begin
						if (!slot_taken(i)) begin
							r.found       = 1'b1;
							r.found_index = i[11:0];
							break;
						end
					end
				end
				KIND_COUNT: begin
					int unsigned n;
					n = 0;
					for (int i = 0; i < MAP_BYTES; i++)
						n += $countones(map_bytes[i]);
					r.allocated_count = n[12:0];
				end
				KIND_CLEAR: begin
					foreach (map_bytes[i])
						map_bytes[i] = 8'h00;
				end
				default: ;
			endcase
			owed.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned exp, int unsigned got);
			if (exp != got) begin
				$error("%s: expected %0d, got %0d", name, exp, got);
				failures++;
			end
		endfunction

		// compare one result item with the oldest owed result
		function void check_result(logic [31:0] data);
			slot_result_t r;
			if (owed.size() == 0) begin
				$error("result item 0x%08h with nothing owed", data);
				failures++;
				return;
			end
			r = owed.pop_front();
			compare_field("is_allocated", r.is_allocated, data[0]);
			compare_field("found", r.found, data[1]);
			compare_field("found_index", r.found_index, data[13:2]);
			compare_field("allocated_count", r.allocated_count, data[26:14]);
			compare_field("pad", 0, data[31:27]);
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [15:0] slot_index
	logic [2:0]  s_axis_tuser = '0;  // [2:0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [0] is_allocated, [1] found, [13:2] found_index, [26:14] allocated_count
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	bitmap_scoreboard sb = new();
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned cycles;
	bit          hold_done;
	int unsigned hold_left;

	allocation_bitmap_first_free #(
		.MAP_BITS(MAP_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: take result items, random stalls, one long hold-off, one stall-free run
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
			results_seen <= results_seen + 1;
		end
		if (!hold_done && results_seen == 150) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (results_seen >= 300 && results_seen < 420) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// offer one request item and wait until it is taken
	task automatic send_item(input logic [2:0] kind, input logic [15:0] idx);
		bit quiet;
		quiet = (items_sent >= 550 && items_sent < 680);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= idx;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(kind, idx);
		items_sent++;
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned pick;
		int unsigned run_len;
		int unsigned base;
		bit          paused;

		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty map, both ends, out of range, spare kinds, clear
		send_item(KIND_COUNT, 16'd0);
		send_item(KIND_FIND, 16'd0);
		send_item(KIND_TEST, 16'd0);
		send_item(KIND_ALLOC, 16'd0);
		send_item(KIND_ALLOC, 16'd4095);
		send_item(KIND_ALLOC, 16'd4096);
		send_item(KIND_ALLOC, 16'hFFFF);
		send_item(KIND_TEST, 16'd0);
		send_item(KIND_TEST, 16'd4095);
		send_item(KIND_TEST, 16'd4096);
		send_item(KIND_TEST, 16'hFFFF);
		send_item(KIND_FIND, 16'd0);
		send_item(KIND_FIND, 16'd4095);
		send_item(KIND_FIND, 16'd4096);
		send_item(KIND_FIND, 16'hFFFF);
		send_item(KIND_COUNT, 16'hFFFF);
		send_item(KIND_SPARE_5, 16'd1);
		send_item(KIND_SPARE_6, 16'hAAAA);
		send_item(KIND_SPARE_7, 16'h5555);
		send_item(KIND_CLEAR, 16'd0);
		send_item(KIND_COUNT, 16'd0);
		send_item(KIND_TEST, 16'd4095);
		send_item(KIND_FIND, 16'd4095);

		// random: mostly allocated runs probed by find and test, plus noise
		while (items_sent < N_ITEMS) begin
			if (!paused && items_sent >= 480) begin
				paused = 1'b1;
				wait_all_results();
			end
			pick = $urandom_range(99);
			if (pick < 50) begin
				run_len = $urandom_range(20, 1);
				if ($urandom_range(3) == 0)
					base = MAP_BITS - run_len;
				else
					base = $urandom_range(MAP_BITS - run_len);
				for (int j = 0; j < run_len; j++)
					send_item(KIND_ALLOC, 16'(base + j));
				send_item(KIND_FIND, 16'(base + $urandom_range(run_len - 1)));
				send_item(KIND_TEST, 16'(base + $urandom_range(run_len)));
				if ($urandom_range(3) == 0)
					send_item(KIND_COUNT, 16'($urandom_range(16'hFFFF)));
			end else if (pick < 65) begin
				send_item(KIND_FIND, 16'($urandom_range(MAP_BITS - 1)));
			end else if (pick < 85) begin
				send_item(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)));
			end else if (pick < 92) begin
				send_item(KIND_TEST, 16'($urandom_range(MAP_BITS - 1)));
			end else if (pick < 97) begin
				send_item(KIND_COUNT, 16'($urandom_range(16'hFFFF)));
			end else begin
				send_item(KIND_CLEAR, 16'($urandom_range(16'hFFFF)));
			end
		end

		// drain, then give the block time to show any stray result
		wait_all_results();
		repeat (MAP_BYTES + 16) @(posedge clk);
		if (sb.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
rtl/abm_pkg.sv
rtl/abm_ram.sv
rtl/abm_byte_eval.sv
rtl/allocation_bitmap_first_free.sv
rtl/abm_checker.sv
tb/allocation_bitmap_first_free_tb.sv
